>>> hdl/modbus_rtu_slave_engine_core_macros.svh
// Assertion macros for the RTL of the slave engine.
`ifndef MODBUS_RTU_SLAVE_ENGINE_CORE_MACROS_SVH
`define MODBUS_RTU_SLAVE_ENGINE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MRS_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("check failed");
`define MRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define MRS_ASSERT(lbl, expr)
`define MRS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hdl/mrs_pkg.sv
`default_nettype none
package mrs_pkg;
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
  } out_t;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  EXC_FLAG  = 8'h80;
  localparam logic [7:0]  STATUS_ON = 8'hFF;

  localparam logic [7:0] FUNC_READ  = 8'h03;
  localparam logic [7:0] FUNC_WRITE = 8'h10;
  localparam logic [7:0] FUNC_INFO  = 8'h11;

  localparam logic [2:0] CFG_SLAVE_ID   = 3'd0;
  localparam logic [2:0] CFG_INFO_BYTES = 3'd1;
  localparam logic [2:0] CFG_INFO_LEN   = 3'd2;
  localparam logic [2:0] CFG_BAD_FUNC   = 3'd3;
  localparam logic [2:0] CFG_BAD_START  = 3'd4;
  localparam logic [2:0] CFG_BAD_COUNT  = 3'd5;
  localparam logic [2:0] CFG_BAD_CHECK  = 3'd6;

  localparam logic [1:0] KIND_EXC   = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_INFO  = 2'd3;
endpackage
`default_nettype wire

>>> hdl/mrs_crc.sv
`default_nettype none
module mrs_crc (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        init,
  input  wire logic        load,
  input  wire logic [7:0]  din,
  output logic      [15:0] crc,
  output logic             busy
);
  logic [15:0] crc_r, crc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;

  always_comb begin
    crc_nxt = crc_r;
    cnt_nxt = cnt_r;
    if (init) begin
      crc_nxt = mrs_pkg::CRC_INIT;
      cnt_nxt = 4'd0;
    end else if (load) begin
      crc_nxt = crc_r ^ {8'h00, din};
      cnt_nxt = 4'd8;
    end else if (cnt_r != 4'd0) begin
      crc_nxt = (crc_r >> 1) ^ (crc_r[0] ? mrs_pkg::CRC_POLY : 16'h0000);
      cnt_nxt = cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= mrs_pkg::CRC_INIT;
      cnt_r <= 4'd0;
    end else begin
      crc_r <= crc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign crc  = crc_r;
  assign busy = (cnt_r != 4'd0);
endmodule
`default_nettype wire

>>> hdl/mrs_frame_buf.sv
`default_nettype none
module mrs_frame_buf #(
  parameter int FRAME_BYTES = 64,
  parameter int AW = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);
  logic [7:0] mem [FRAME_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

>>> hdl/modbus_rtu_slave_engine_core.sv
`default_nettype none
`include "modbus_rtu_slave_engine_core_macros.svh"
// Modbus RTU slave: from the third received byte on, each accepted byte makes the block fold the
// byte two places back into the CRC through the single bitwise CRC unit, with in_ready low until
// the fold is done. At frame end a decision state follows; a register write (function 0x10) then
// reads the high and low byte of each register through the frame buffer read port and writes it,
// and every reply body byte goes through the same CRC unit, plus any wait for the output side.
// The frame buffer needs no clearing after reset, so the block is ready as soon as reset is released.
module modbus_rtu_slave_engine_core #(
  parameter int NUM_REGS    = 16,
  parameter int FRAME_BYTES = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mrs_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mrs_pkg::out_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [63:0]   cfg_data
);
  localparam int FW = $clog2(FRAME_BYTES + 1);
  localparam int AW = $clog2(FRAME_BYTES);
  localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int CW = $clog2(NUM_REGS + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SHIFT  = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_WRITE  = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [7:0]  slave_id_r, bad_func_r, bad_start_r, bad_count_r, bad_check_r;
  logic [63:0] info_r;
  logic [3:0]  info_len_r;

  logic [2:0]    state_r, ret_r;
  logic [FW-1:0] fill_r;
  logic          ovf_r;
  logic [7:0]    hdr_r [6];
  logic [7:0]    prev1_r, prev2_r;
  logic [1:0]    kind_r;
  logic [7:0]    code_r;
  logic [6:0]    len_r, idx_r;
  logic [CW-1:0] wi_r;
  logic [1:0]    ph_r;
  logic [7:0]    hi_r;
  logic [15:0]   regs_r [NUM_REGS];
  logic          out_valid_r;
  mrs_pkg::out_t out_r;

  logic        crc_init, crc_load, crc_busy;
  logic [7:0]  crc_din;
  logic [15:0] crc;
  logic        mem_we;
  logic [AW-1:0] mem_raddr;
  logic [7:0]  mem_rdata;

  logic        in_acc, cfg_acc, store_ok;
  logic [15:0] start_w, count_w;
  logic [3:0]  info_eff;
  logic [7:0]  body_byte;
  logic [6:0]  rk, ik;
  logic [RW-1:0] rd_idx, wr_idx;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign store_ok  = (fill_r < FW'(FRAME_BYTES));
  assign mem_we    = in_acc && store_ok;
  assign start_w   = {hdr_r[2], hdr_r[3]};
  assign count_w   = {hdr_r[4], hdr_r[5]};
  assign info_eff  = (info_len_r > 4'd8) ? 4'd8 : info_len_r;
  assign mem_raddr = AW'(32'd7 + 32'(wi_r) * 32'd2 + 32'(ph_r[0]));
  assign rk        = idx_r - 7'd3;
  assign ik        = idx_r - 7'd5;
  assign rd_idx    = start_w[RW-1:0] + RW'(rk[6:1]);
  assign wr_idx    = start_w[RW-1:0] + RW'(wi_r);

  mrs_frame_buf #(.FRAME_BYTES(FRAME_BYTES), .AW(AW)) u_buf (
    .clk(clk), .we(mem_we), .waddr(fill_r[AW-1:0]), .wdata(in_data.rx_byte),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  mrs_crc u_crc (
    .clk(clk), .rst_n(rst_n), .init(crc_init), .load(crc_load), .din(crc_din),
    .crc(crc), .busy(crc_busy)
  );

  // Reply body byte at the current index.
  always_comb begin
    body_byte = slave_id_r;
    unique case (kind_r)
      mrs_pkg::KIND_EXC: begin
        if (idx_r == 7'd1) body_byte = hdr_r[1] | mrs_pkg::EXC_FLAG;
        else if (idx_r == 7'd2) body_byte = code_r;
      end
      mrs_pkg::KIND_READ: begin
        if (idx_r == 7'd1) body_byte = hdr_r[1];
        else if (idx_r == 7'd2) body_byte = {count_w[6:0], 1'b0};
        else if (idx_r >= 7'd3) begin
          body_byte = rk[0] ? regs_r[rd_idx][7:0] : regs_r[rd_idx][15:8];
        end
      end
      mrs_pkg::KIND_WRITE: begin
        if (idx_r == 7'd1) body_byte = hdr_r[1];
        else if (idx_r == 7'd2) body_byte = hdr_r[2];
        else if (idx_r == 7'd3) body_byte = hdr_r[3];
        else if (idx_r == 7'd4) body_byte = hdr_r[4];
        else if (idx_r == 7'd5) body_byte = hdr_r[5];
      end
      mrs_pkg::KIND_INFO: begin
        if (idx_r == 7'd1) body_byte = hdr_r[1];
        else if (idx_r == 7'd2) body_byte = 8'd2 + 8'(info_eff);
        else if (idx_r == 7'd4) body_byte = mrs_pkg::STATUS_ON;
        else if (idx_r >= 7'd5) body_byte = info_r[(6'd56 - {ik[2:0], 3'b000}) +: 8];
      end
      default: body_byte = slave_id_r;
    endcase
  end

  always_comb begin
    crc_init = 1'b0;
    crc_load = 1'b0;
    crc_din  = prev2_r;
    if (state_r == ST_IDLE) begin
      crc_load = mem_we && (fill_r >= FW'(2));
    end else if (state_r == ST_DECIDE) begin
      crc_init = 1'b1;
    end else if (state_r == ST_EMIT && !out_valid_r) begin
      if (idx_r < len_r) begin
        crc_load = 1'b1;
        crc_din  = body_byte;
      end else if (idx_r != len_r) begin
        crc_init = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_id_r  <= 8'd1;
      info_r      <= 64'd0;
      info_len_r  <= 4'd0;
      bad_func_r  <= 8'd1;
      bad_start_r <= 8'd2;
      bad_count_r <= 8'd3;
      bad_check_r <= 8'd4;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        mrs_pkg::CFG_SLAVE_ID:   slave_id_r  <= cfg_data[7:0];
        mrs_pkg::CFG_INFO_BYTES: info_r      <= cfg_data;
        mrs_pkg::CFG_INFO_LEN:   info_len_r  <= cfg_data[3:0];
        mrs_pkg::CFG_BAD_FUNC:   bad_func_r  <= cfg_data[7:0];
        mrs_pkg::CFG_BAD_START:  bad_start_r <= cfg_data[7:0];
        mrs_pkg::CFG_BAD_COUNT:  bad_count_r <= cfg_data[7:0];
        mrs_pkg::CFG_BAD_CHECK:  bad_check_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      len_r       <= '0;
      wi_r        <= '0;
      ph_r        <= '0;
      kind_r      <= mrs_pkg::KIND_EXC;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= 16'h0000;
      end
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (store_ok) begin
              fill_r  <= fill_r + FW'(1);
              prev1_r <= in_data.rx_byte;
              prev2_r <= prev1_r;
              if (fill_r < FW'(6)) begin
                hdr_r[fill_r[2:0]] <= in_data.rx_byte;
              end
            end else begin
              ovf_r <= 1'b1;
            end
            if (crc_load) begin
              state_r <= ST_SHIFT;
              ret_r   <= in_data.frame_end ? ST_DECIDE : ST_IDLE;
            end else if (in_data.frame_end) begin
              state_r <= ST_DECIDE;
            end
          end
        end
        ST_SHIFT: begin
          if (!crc_busy) begin
            state_r <= ret_r;
          end
        end
        ST_DECIDE: begin
          fill_r <= '0;
          ovf_r  <= 1'b0;
          idx_r  <= '0;
          wi_r   <= '0;
          ph_r   <= '0;
          // Priority follows the order of the protocol checks.
          priority if (ovf_r || fill_r < FW'(4) || hdr_r[0] != slave_id_r) begin
            state_r <= ST_IDLE;
          end else if (crc != {prev1_r, prev2_r}) begin
            state_r <= ST_EMIT;
            kind_r  <= mrs_pkg::KIND_EXC;
            len_r   <= 7'd3;
            code_r  <= bad_check_r;
          end else if (hdr_r[1] == mrs_pkg::FUNC_READ || hdr_r[1] == mrs_pkg::FUNC_WRITE) begin
            priority if (fill_r < FW'(8)) begin
              state_r <= ST_IDLE;
            end else if (start_w >= 16'(NUM_REGS)) begin
              state_r <= ST_EMIT;
              kind_r  <= mrs_pkg::KIND_EXC;
              len_r   <= 7'd3;
              code_r  <= bad_start_r;
            end else if (17'(start_w) + 17'(count_w) > 17'(NUM_REGS)) begin
              state_r <= ST_EMIT;
              kind_r  <= mrs_pkg::KIND_EXC;
              len_r   <= 7'd3;
              code_r  <= bad_count_r;
            end else if (hdr_r[1] == mrs_pkg::FUNC_READ) begin
              state_r <= ST_EMIT;
              kind_r  <= mrs_pkg::KIND_READ;
              len_r   <= 7'd3 + {count_w[5:0], 1'b0};
            end else if (17'(fill_r) < {count_w, 1'b0} + 17'd9) begin
              state_r <= ST_IDLE;
            end else begin
              kind_r  <= mrs_pkg::KIND_WRITE;
              len_r   <= 7'd6;
              state_r <= ST_WRITE;
            end
          end else if (hdr_r[1] == mrs_pkg::FUNC_INFO) begin
            state_r <= ST_EMIT;
            kind_r  <= mrs_pkg::KIND_INFO;
            len_r   <= 7'd5 + 7'(info_eff);
          end else begin
            state_r <= ST_EMIT;
            kind_r  <= mrs_pkg::KIND_EXC;
            len_r   <= 7'd3;
            code_r  <= bad_func_r;
          end
        end
        ST_WRITE: begin
          // Each register: read high byte, read low byte, then write.
          if (wi_r == count_w[CW-1:0]) begin
            state_r <= ST_EMIT;
          end else if (ph_r == 2'd0) begin
            ph_r <= 2'd1;
          end else if (ph_r == 2'd1) begin
            hi_r <= mem_rdata;
            ph_r <= 2'd2;
          end else begin
            regs_r[wr_idx] <= {hi_r, mem_rdata};
            wi_r <= wi_r + CW'(1);
            ph_r <= 2'd0;
          end
        end
        ST_EMIT: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            idx_r       <= idx_r + 7'd1;
            if (idx_r < len_r) begin
              out_r   <= '{tx_byte: body_byte, tx_last: 1'b0};
              state_r <= ST_SHIFT;
              ret_r   <= ST_EMIT;
            end else if (idx_r == len_r) begin
              out_r <= '{tx_byte: crc[7:0], tx_last: 1'b0};
            end else begin
              out_r   <= '{tx_byte: crc[15:8], tx_last: 1'b1};
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `MRS_ASSERT(a_fill_bound, fill_r <= FW'(FRAME_BYTES))
  `MRS_ASSERT_NEXT(a_end_leaves_idle, in_acc && in_data.frame_end, state_r != ST_IDLE)
  `MRS_ASSERT(a_idle_crc_quiet, !(in_ready && crc_busy))
endmodule
`default_nettype wire
